// ===== hw/rtl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// register map, configuration bundle, per-word control, median window and result group types
// ----------------------------------------------------------------------------
package mf3_pkg;

  // parameter defaults
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CHANNELS_DEF  = 3;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;
  localparam logic        ENABLE_RST = 1'b0;

  // result slots within one input word, in raster order
  localparam logic [1:0] SLOT_MED  = 2'd0;  // window center, median or border
  localparam logic [1:0] SLOT_EDGE = 2'd1;  // last column of the previous row
  localparam logic [1:0] SLOT_LAST = 2'd2;  // pixel of the last row itself

  typedef struct packed {
    logic [11:0] width;
    logic [15:0] height;
    logic        enable;
  } cfg_t;

  // per-word control carried down the pipeline
  typedef struct packed {
    logic [2:0]  mask;    // which result slots this word produces
    logic        border;  // center slot passes through
    logic [15:0] row;
    logic [10:0] col;
  } ctl_t;

  // one channel of the 3x3 window: [column][row], column 0 oldest
  typedef logic [2:0][2:0][7:0] win_t;

  // up to three results of one word: vals[slot][channel]
  typedef struct packed {
    logic [2:0]           mask;
    logic [15:0]          row;
    logic [10:0]          col;
    logic [2:0][2:0][7:0] vals;
  } grp_t;

endpackage

// ===== hw/rtl/mf3_regs.sv =====
// ----------------------------------------------------------------------------
// mf3_regs: configuration registers
// apb-style write and read of image width, image height and filter enable
// ----------------------------------------------------------------------------
module mf3_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf3_pkg::PADDR_W-1:0]   paddr,
  input  logic [mf3_pkg::PDATA_W-1:0]   pwdata,
  output logic [mf3_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mf3_pkg::cfg_t                 cfg
);

  logic       wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= mf3_pkg::WIDTH_RST;
      cfg.height <= mf3_pkg::HEIGHT_RST;
      cfg.enable <= mf3_pkg::ENABLE_RST;
    end else if (wr) begin
      case (reg_idx)
        mf3_pkg::REG_WIDTH:  cfg.width  <= pwdata[11:0];
        mf3_pkg::REG_HEIGHT: cfg.height <= pwdata[15:0];
        mf3_pkg::REG_ENABLE: cfg.enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      mf3_pkg::REG_WIDTH:  prdata = {20'd0, cfg.width};
      mf3_pkg::REG_HEIGHT: prdata = {16'd0, cfg.height};
      mf3_pkg::REG_ENABLE: prdata = {31'd0, cfg.enable};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/mf3_lane.sv =====
// ----------------------------------------------------------------------------
// mf3_lane: median of nine for one channel
// sorts the three columns, then combines column minima, middles and maxima
// ----------------------------------------------------------------------------
module mf3_lane (
  input  logic          clk,
  input  logic          en_a,
  input  logic          en_b,
  input  mf3_pkg::win_t win,
  output logic [7:0]    med
);

  logic [2:0][2:0][7:0] srt;  // [column][rank], rank 0 smallest
  logic [7:0]           lo;
  logic [7:0]           md;
  logic [7:0]           hi;

  function automatic logic [7:0] mx(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] mn(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] md3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return mx(mn(a, b), mn(mx(a, b), c));
  endfunction

  // first stage: sort each column
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int j = 0; j < 3; j++) begin
        srt[j][0] <= mn(mn(win[j][0], win[j][1]), win[j][2]);
        srt[j][1] <= md3(win[j][0], win[j][1], win[j][2]);
        srt[j][2] <= mx(mx(win[j][0], win[j][1]), win[j][2]);
      end
    end
  end

  // second stage: max of minima, median of middles, min of maxima
  always_ff @(posedge clk) begin
    if (en_b) begin
      lo <= mx(mx(srt[0][0], srt[1][0]), srt[2][0]);
      md <= md3(srt[0][1], srt[1][1], srt[2][1]);
      hi <= mn(mn(srt[0][2], srt[1][2]), srt[2][2]);
    end
  end

  // the fifth of nine is the median of those three
  assign med = md3(lo, md, hi);

endmodule

// ===== hw/rtl/mf3_out.sv =====
// ----------------------------------------------------------------------------
// mf3_out: result merge and output register
// holds the results of one word and, while out_ready holds, hands them out one per cycle in order
// ----------------------------------------------------------------------------
module mf3_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  mf3_pkg::grp_t grp_i,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    filtered_a,
  output logic [7:0]    filtered_b,
  output logic [7:0]    filtered_c,
  output logic [15:0]   out_row,
  output logic [10:0]   out_col,
  output logic          last_of_run
);

  logic [2:0]           mask;
  logic [15:0]          row;
  logic [10:0]          col;
  logic [2:0][2:0][7:0] vals;
  logic [1:0]           slot;

  // first pending slot
  always_comb begin
    if (mask[mf3_pkg::SLOT_MED])       slot = mf3_pkg::SLOT_MED;
    else if (mask[mf3_pkg::SLOT_EDGE]) slot = mf3_pkg::SLOT_EDGE;
    else                               slot = mf3_pkg::SLOT_LAST;
  end

  assign out_valid   = |mask;
  assign last_of_run = $onehot(mask);
  assign ready       = !out_valid || (out_ready && last_of_run);

  assign filtered_a = vals[slot][0];
  assign filtered_b = vals[slot][1];
  assign filtered_c = vals[slot][2];
  assign out_row    = (slot == mf3_pkg::SLOT_LAST) ? row : row - 16'd1;
  assign out_col    = (slot == mf3_pkg::SLOT_MED) ? col - 11'd1 : col;

  // pending mask, lowest bit retires on each handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= grp_i.mask;
    end else if (out_valid && out_ready) begin
      mask <= mask & (mask - 3'd1);
    end
  end

  // group payload
  always_ff @(posedge clk) begin
    if (load) begin
      row  <= grp_i.row;
      col  <= grp_i.col;
      vals <= grp_i.vals;
    end
  end

endmodule

// ===== hw/rtl/median_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_top: per-channel 3x3 median filter on a raster stream
// line memory, sliding window, one median lane per channel, result merge
// ----------------------------------------------------------------------------
// path: an accepted pixel passes stage 1, stage 2 and stage 3 into the output register, where its result shows
// throughput: 1 pixel per cycle while out_ready holds and a pixel gives at most one result; a row
//   end gives two results and a pixel of the last row two (one at its start, three at its end), all
//   through the single output port that the merge stage drains one result per cycle
// reset: counters, window, registers and pipeline clear; the
//   line memory is not cleared and needs no pass after reset
module median_filter_3x3_top #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = mf3_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf3_pkg::PADDR_W-1:0]   paddr,
  input  logic [mf3_pkg::PDATA_W-1:0]   pwdata,
  output logic [mf3_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    sample_a,
  input  logic [7:0]                    sample_b,
  input  logic [7:0]                    sample_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    filtered_a,
  output logic [7:0]                    filtered_b,
  output logic [7:0]                    filtered_c,
  output logic [15:0]                   out_row,
  output logic [10:0]                   out_col,
  output logic                          last_of_run
);

  localparam int LANES = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CAP   = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam logic [11:0] WCAP = 12'(CAP);

  typedef logic [LANES-1:0][7:0] lpix_t;
  typedef lpix_t [2:0]           lcol_t;  // [row], 0 = two rows up
  typedef struct packed {
    lpix_t mid;
    lpix_t up;
  } lent_t;

  mf3_pkg::cfg_t cfg;
  mf3_pkg::ctl_t ctl_in;
  mf3_pkg::ctl_t ctl1;
  mf3_pkg::ctl_t ctl2;
  mf3_pkg::ctl_t ctl3;
  mf3_pkg::grp_t grp;
  mf3_pkg::win_t lane_win [LANES];

  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic [11:0] col_ext;
  logic        row_end;
  logic        last_row;
  logic [15:0] row_counter;
  logic [10:0] column_counter;

  logic        accept;
  logic        adv1;
  logic        adv2;
  logic        adv3;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        g_ready;

  logic [2:0][7:0] smp;
  lpix_t px_in;
  lpix_t px1;
  lpix_t px2;
  lpix_t px3;
  lpix_t mid2;
  lpix_t mid3;
  lpix_t ctr2;
  lpix_t ctr3;
  lpix_t med;

  lent_t line_mem [MAX_WIDTH];
  lent_t mem_rd;
  lcol_t cur_col;
  lcol_t win_new;
  lcol_t win_old;

  // configuration registers
  mf3_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamp frame size
  always_comb begin
    if (cfg.width < 12'd3)     w_eff = 12'd3;
    else if (cfg.width > WCAP) w_eff = WCAP;
    else                       w_eff = cfg.width;
    if (cfg.height < 16'd3)    h_eff = 16'd3;
    else                       h_eff = cfg.height;
  end

  assign col_ext  = {1'b0, column_counter};
  assign row_end  = col_ext >= (w_eff - 12'd1);
  assign last_row = row_counter >= (h_eff - 16'd1);

  // which results this word produces
  always_comb begin
    ctl_in.mask[mf3_pkg::SLOT_MED]  = (row_counter != 16'd0) && (column_counter != 11'd0);
    ctl_in.mask[mf3_pkg::SLOT_EDGE] = (row_counter != 16'd0) && row_end;
    ctl_in.mask[mf3_pkg::SLOT_LAST] = last_row;
    ctl_in.border = (row_counter == 16'd1) || (column_counter == 11'd1) ||
                    (col_ext >= w_eff) || !cfg.enable;
    ctl_in.row    = row_counter;
    ctl_in.col    = column_counter;
  end

  // pack the used channels
  assign smp = {sample_c, sample_b, sample_a};
  always_comb begin
    for (int ch = 0; ch < LANES; ch++) begin
      px_in[ch] = smp[ch];
    end
  end

  // pipeline flow, each stage moves when the next one frees up
  assign adv3     = v3 && g_ready;
  assign adv2     = v2 && (!v3 || adv3);
  assign adv1     = v1 && (!v2 || adv2);
  assign in_ready = !v1 || adv1;
  assign accept   = in_valid && in_ready;

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_counter <= '0;
        row_counter    <= last_row ? 16'd0 : row_counter + 16'd1;
      end else begin
        column_counter <= column_counter + 11'd1;
      end
    end
  end

  // line memory: read on accept, write back when the word leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rd <= line_mem[AW'(column_counter)];
    end
    if (adv1) begin
      line_mem[AW'(ctl1.col)] <= '{mid: px1, up: mem_rd.mid};
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept)    v1 <= 1'b1;
      else if (adv1) v1 <= 1'b0;
      if (adv1)      v2 <= 1'b1;
      else if (adv2) v2 <= 1'b0;
      if (adv2)      v3 <= 1'b1;
      else if (adv3) v3 <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      px1  <= px_in;
      ctl1 <= ctl_in;
    end
  end

  assign cur_col[0] = mem_rd.up;
  assign cur_col[1] = mem_rd.mid;
  assign cur_col[2] = px1;

  // sliding window of the two previous columns
  always_ff @(posedge clk) begin
    if (rst) begin
      win_new <= '0;
      win_old <= '0;
    end else if (adv1) begin
      win_old <= win_new;
      win_new <= cur_col;
    end
  end

  // lane windows, one per channel
  always_comb begin
    for (int ch = 0; ch < LANES; ch++) begin
      for (int i = 0; i < 3; i++) begin
        lane_win[ch][0][i] = win_old[i][ch];
        lane_win[ch][1][i] = win_new[i][ch];
        lane_win[ch][2][i] = cur_col[i][ch];
      end
    end
  end

  // stages 2 and 3 carry passthrough values beside the lanes
  always_ff @(posedge clk) begin
    if (adv1) begin
      ctl2 <= ctl1;
      ctr2 <= win_new[1];
      mid2 <= mem_rd.mid;
      px2  <= px1;
    end
    if (adv2) begin
      ctl3 <= ctl2;
      ctr3 <= ctr2;
      mid3 <= mid2;
      px3  <= px2;
    end
  end

  // median lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mf3_lane u_lane (
      .clk  (clk),
      .en_a (adv1),
      .en_b (adv2),
      .win  (lane_win[g]),
      .med  (med[g])
    );
  end

  // result group of one word, missing channels read as zero
  always_comb begin
    grp.mask = ctl3.mask;
    grp.row  = ctl3.row;
    grp.col  = ctl3.col;
    grp.vals = '0;
    for (int ch = 0; ch < LANES; ch++) begin
      grp.vals[mf3_pkg::SLOT_MED][ch]  = ctl3.border ? ctr3[ch] : med[ch];
      grp.vals[mf3_pkg::SLOT_EDGE][ch] = mid3[ch];
      grp.vals[mf3_pkg::SLOT_LAST][ch] = px3[ch];
    end
  end

  // merge and output register
  mf3_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (adv3),
    .grp_i       (grp),
    .ready       (g_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .filtered_a  (filtered_a),
    .filtered_b  (filtered_b),
    .filtered_c  (filtered_c),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

  // line memory read never meets the pending write
  a_mem_no_clash: assert property (@(posedge clk) disable iff (rst)
    (accept && adv1) |-> (column_counter != ctl1.col))
    else $error("line memory read and write at the same address");

  // a group with results shows on the output next cycle
  a_group_shows: assert property (@(posedge clk) disable iff (rst)
    (adv3 && (grp.mask != 3'b000)) |=> out_valid)
    else $error("result group lost in merge stage");

  // the merge stage empties after its last result
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run && !adv3) |=> !out_valid)
    else $error("merge stage repeats a result");

endmodule
